FILE: rtl/core/sha1md_pkg.sv
// ---------------------------------------------------------------------------
// sha1md_pkg
// shared types, constants and round functions for the sha-1 digest core
// ---------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_W     = 512;
    localparam int unsigned COUNT_W     = 61;
    localparam int unsigned FILL_W      = 6;
    localparam int unsigned ROUND_W     = 7;
    localparam int unsigned WIDX_W      = 3;
    localparam int unsigned NUM_CHAIN   = 5;

    localparam logic [FILL_W-1:0]  FILL_BLOCK_LAST = 6'd63;
    localparam logic [FILL_W-1:0]  FILL_LEN_FIRST  = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST      = 7'd79;
    localparam logic [ROUND_W-1:0] ROUND_P1_FIRST  = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_P2_FIRST  = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_P3_FIRST  = 7'd60;
    localparam logic [WIDX_W-1:0]  WIDX_LAST       = 3'd4;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

    localparam logic [WORD_W-1:0] CHAIN_IV [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_P0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_P1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_P2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_P3 = 32'hCA62C1D6;

    typedef enum logic [1:0] {
        RP_CHOOSE  = 2'd0,
        RP_PARITY1 = 2'd1,
        RP_MAJ     = 2'd2,
        RP_PARITY2 = 2'd3
    } round_phase_t;

    typedef enum logic [1:0] {
        PAD_MARK = 2'd0,
        PAD_ZERO = 2'd1,
        PAD_LEN  = 2'd2
    } pad_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_PAD_MARK = 4'd1,
        ST_PAD_ZERO = 4'd2,
        ST_PAD_LEN  = 4'd3,
        ST_LOAD     = 4'd4,
        ST_ROUND    = 4'd5,
        ST_FINISH   = 4'd6,
        ST_EMIT     = 4'd7
    } ctrl_state_t;

    // where to go once a block has been compressed
    typedef enum logic [1:0] {
        PH_MSG   = 2'd0,
        PH_MARK  = 2'd1,
        PH_PAD   = 2'd2,
        PH_FINAL = 2'd3
    } phase_t;

    typedef struct packed {
        logic               load_byte;
        logic               pad_byte;
        pad_sel_t           pad_sel;
        logic               start;
        logic               round;
        round_phase_t       rphase;
        logic               finish;
        logic               emit;
        logic [WIDX_W-1:0]  emit_index;
        logic               init;
    } dp_cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              out_free;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] round_f(input round_phase_t rp,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c,
                                                  input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] f;
        unique case (rp)
            RP_CHOOSE: f = (b & c) | (~b & d);
            RP_MAJ:    f = (b & c) | (b & d) | (c & d);
            default:   f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input round_phase_t rp);
        logic [WORD_W-1:0] k;
        unique case (rp)
            RP_CHOOSE:  k = K_P0;
            RP_PARITY1: k = K_P1;
            RP_MAJ:     k = K_P2;
            default:    k = K_P3;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sha1md_ctrl.sv
// ---------------------------------------------------------------------------
// sha1md_ctrl
// sequencer: byte intake, padding, 80-round compression and digest output
// ---------------------------------------------------------------------------
`default_nettype none

module sha1md_ctrl
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    input  wire                   byte_present,
    input  wire                   end_of_message,
    output logic                  in_ready,
    input  sha1md_pkg::dp_status_t status,
    output sha1md_pkg::dp_cmd_t   cmd
);

    sha1md_pkg::ctrl_state_t state_reg, state_next;
    sha1md_pkg::phase_t      phase_reg, phase_next;
    logic [sha1md_pkg::ROUND_W-1:0] round_reg, round_next;
    logic [sha1md_pkg::WIDX_W-1:0]  word_reg, word_next;

    logic block_full;
    logic accept;

    assign block_full = (status.fill == sha1md_pkg::FILL_BLOCK_LAST);
    assign accept     = in_valid && (state_reg == sha1md_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1md_pkg::ST_IDLE;
            phase_reg <= sha1md_pkg::PH_MSG;
            round_reg <= '0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            word_reg  <= word_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        round_next = round_reg;
        word_next  = word_reg;
        unique case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present && block_full)
                    begin
                        state_next = sha1md_pkg::ST_LOAD;
                        phase_next = end_of_message ? sha1md_pkg::PH_MARK
                                                    : sha1md_pkg::PH_MSG;
                    end
                    else if (end_of_message)
                    begin
                        state_next = sha1md_pkg::ST_PAD_MARK;
                    end
                end
            end
            sha1md_pkg::ST_PAD_MARK:
            begin
                if (block_full)
                begin
                    state_next = sha1md_pkg::ST_LOAD;
                    phase_next = sha1md_pkg::PH_PAD;
                end
                else
                begin
                    state_next = sha1md_pkg::ST_PAD_ZERO;
                end
            end
            sha1md_pkg::ST_PAD_ZERO:
            begin
                if (status.fill == sha1md_pkg::FILL_LEN_FIRST)
                begin
                    state_next = sha1md_pkg::ST_PAD_LEN;
                end
                else if (block_full)
                begin
                    state_next = sha1md_pkg::ST_LOAD;
                    phase_next = sha1md_pkg::PH_PAD;
                end
            end
            sha1md_pkg::ST_PAD_LEN:
            begin
                if (block_full)
                begin
                    state_next = sha1md_pkg::ST_LOAD;
                    phase_next = sha1md_pkg::PH_FINAL;
                end
            end
            sha1md_pkg::ST_LOAD:
            begin
                round_next = '0;
                state_next = sha1md_pkg::ST_ROUND;
            end
            sha1md_pkg::ST_ROUND:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == sha1md_pkg::ROUND_LAST)
                begin
                    state_next = sha1md_pkg::ST_FINISH;
                end
            end
            sha1md_pkg::ST_FINISH:
            begin
                unique case (phase_reg)
                    sha1md_pkg::PH_MARK:  state_next = sha1md_pkg::ST_PAD_MARK;
                    sha1md_pkg::PH_PAD:   state_next = sha1md_pkg::ST_PAD_ZERO;
                    sha1md_pkg::PH_FINAL: state_next = sha1md_pkg::ST_EMIT;
                    default:              state_next = sha1md_pkg::ST_IDLE;
                endcase
                word_next = '0;
            end
            sha1md_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (word_reg == sha1md_pkg::WIDX_LAST)
                    begin
                        word_next  = '0;
                        phase_next = sha1md_pkg::PH_MSG;
                        state_next = sha1md_pkg::ST_IDLE;
                    end
                    else
                    begin
                        word_next = word_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sha1md_pkg::ST_IDLE;
                phase_next = sha1md_pkg::PH_MSG;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.pad_sel    = sha1md_pkg::PAD_ZERO;
        cmd.rphase     = sha1md_pkg::RP_CHOOSE;
        cmd.emit_index = word_reg;
        priority if (round_reg < sha1md_pkg::ROUND_P1_FIRST)
            cmd.rphase = sha1md_pkg::RP_CHOOSE;
        else if (round_reg < sha1md_pkg::ROUND_P2_FIRST)
            cmd.rphase = sha1md_pkg::RP_PARITY1;
        else if (round_reg < sha1md_pkg::ROUND_P3_FIRST)
            cmd.rphase = sha1md_pkg::RP_MAJ;
        else
            cmd.rphase = sha1md_pkg::RP_PARITY2;

        unique case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_byte = accept && byte_present;
            end
            sha1md_pkg::ST_PAD_MARK:
            begin
                cmd.pad_byte = 1'b1;
                cmd.pad_sel  = sha1md_pkg::PAD_MARK;
            end
            sha1md_pkg::ST_PAD_ZERO:
            begin
                cmd.pad_byte = (status.fill != sha1md_pkg::FILL_LEN_FIRST);
                cmd.pad_sel  = sha1md_pkg::PAD_ZERO;
            end
            sha1md_pkg::ST_PAD_LEN:
            begin
                cmd.pad_byte = 1'b1;
                cmd.pad_sel  = sha1md_pkg::PAD_LEN;
            end
            sha1md_pkg::ST_LOAD:   cmd.start  = 1'b1;
            sha1md_pkg::ST_ROUND:  cmd.round  = 1'b1;
            sha1md_pkg::ST_FINISH: cmd.finish = 1'b1;
            sha1md_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
                cmd.init = status.out_free && (word_reg == sha1md_pkg::WIDX_LAST);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha1md_datapath.sv
// ---------------------------------------------------------------------------
// sha1md_datapath
// block shift register, rolling schedule, round unit, chaining words, output
// ---------------------------------------------------------------------------
`default_nettype none

module sha1md_datapath
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire  [7:0]                            data_byte,
    input  sha1md_pkg::dp_cmd_t                   cmd,
    output sha1md_pkg::dp_status_t                status,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [sha1md_pkg::WORD_W-1:0]         out_word,
    output logic [sha1md_pkg::WIDX_W-1:0]         out_index,
    output logic                                  out_last
);

    localparam int unsigned W  = sha1md_pkg::WORD_W;
    localparam int unsigned BW = sha1md_pkg::BLOCK_W;

    logic [BW-1:0] block_reg, block_next;
    logic [sha1md_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [sha1md_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [W-1:0] h_reg [sha1md_pkg::NUM_CHAIN];
    logic [W-1:0] h_next [sha1md_pkg::NUM_CHAIN];
    logic [W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [W-1:0] a_next, b_next, c_next, d_next, e_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_word_reg;
    logic [sha1md_pkg::WIDX_W-1:0] out_index_reg;
    logic         out_last_reg;

    logic [63:0]  bit_len;
    logic [5:0]   len_base;
    logic [7:0]   len_byte;
    logic [7:0]   shift_byte;
    logic [W-1:0] w_cur, w_mix, w_new, a_rot, temp;

    // the block holds W[t] .. W[t+15] during the rounds, W[t] at the top
    assign w_cur = block_reg[BW-1 -: W];
    assign w_mix = block_reg[BW-1-13*W -: W] ^ block_reg[BW-1-8*W -: W]
                 ^ block_reg[BW-1-2*W -: W] ^ w_cur;
    assign w_new = {w_mix[W-2:0], w_mix[W-1]};
    assign a_rot = {a_reg[W-6:0], a_reg[W-1 -: 5]};
    assign temp  = a_rot + sha1md_pkg::round_f(cmd.rphase, b_reg, c_reg, d_reg)
                 + e_reg + sha1md_pkg::round_k(cmd.rphase) + w_cur;

    // length bytes go out most significant first
    assign bit_len  = {count_reg, 3'b000};
    assign len_base = {3'd7 - fill_reg[2:0], 3'b000};
    assign len_byte = bit_len[len_base +: 8];

    always_comb
    begin
        unique case (cmd.pad_sel)
            sha1md_pkg::PAD_MARK: shift_byte = sha1md_pkg::PAD_MARK_BYTE;
            sha1md_pkg::PAD_LEN:  shift_byte = len_byte;
            default:              shift_byte = 8'h00;
        endcase
        if (cmd.load_byte)
            shift_byte = data_byte;
    end

    always_comb
    begin
        block_next = block_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        h_next = h_reg;
        if (cmd.load_byte || cmd.pad_byte)
        begin
            block_next = {block_reg[BW-9:0], shift_byte};
            fill_next  = fill_reg + 1'b1;
        end
        if (cmd.load_byte)
            count_next = count_reg + 1'b1;
        if (cmd.start)
        begin
            a_next = h_reg[0];
            b_next = h_reg[1];
            c_next = h_reg[2];
            d_next = h_reg[3];
            e_next = h_reg[4];
        end
        if (cmd.round)
        begin
            block_next = {block_reg[BW-W-1:0], w_new};
            a_next = temp;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[W-1:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
        if (cmd.finish)
        begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end
        if (cmd.init)
        begin
            h_next     = sha1md_pkg::CHAIN_IV;
            count_next = '0;
        end
    end

    assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            count_reg     <= '0;
            h_reg         <= sha1md_pkg::CHAIN_IV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        if (cmd.emit)
        begin
            out_word_reg  <= h_reg[cmd.emit_index];
            out_index_reg <= cmd.emit_index;
            out_last_reg  <= (cmd.emit_index == sha1md_pkg::WIDX_LAST);
        end
    end

    assign status.fill     = fill_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sha1_message_digest.sv
// ---------------------------------------------------------------------------
// sha1_message_digest
// byte-wide sha-1 hashing core with padding and five-word digest output
// ---------------------------------------------------------------------------
// channel  direction  beat contents
// s_*      in         tdata: data_byte, tuser: byte_present, tlast: end_of_message
// m_*      out        tdata: digest_word, tuser: word_index, tlast: last_word
//
// message bytes are taken one per cycle; every 64th byte then holds input off for a compression
// (operand load, 80 rounds on a single round unit, chaining add).
// an end beat pads one byte per cycle up to the block end, with one more block of
// padding and compression when fewer than 9 bytes are left,
// then five digest beats leave through an output register, one per cycle.
// s_tready is high only between messages and blocks; m_tready stalls only the
// digest beats. reset is asynchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tuser,   // [0] byte_present
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    sha1md_pkg::dp_cmd_t    cmd;
    sha1md_pkg::dp_status_t status;

    sha1md_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .byte_present   (s_tuser),
        .end_of_message (s_tlast),
        .in_ready       (s_tready),
        .status         (status),
        .cmd            (cmd)
    );

    sha1md_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_index (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: verif/tb_sha1_message_digest.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sha1_message_digest
// self-checking bench for the byte-wide sha-1 core: a table of directed
// messages, then random messages of mixed lengths with idle beats between
// them, every digest word checked against a known or behavioural hash of the stream
// ---------------------------------------------------------------------------

module tb_sha1_message_digest;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         last;
        logic         known;
        logic [159:0] digest;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    localparam int NUM_ROWS     = 16;
    localparam int RANDOM_ITEMS = 370;
    localparam int TAIL_CYCLES  = 200;

    localparam logic [159:0] SHA_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // hash state mirrored from the accepted input stream
    logic [31:0] chain_h [sha1md_pkg::NUM_CHAIN];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_bytes;

    digest_beat_t digest_q [$];
    stim_row_t    dir_rows [NUM_ROWS];
    int           boundary_len [6] = '{54, 55, 56, 63, 64, 65};

    int mismatches    = 0;
    int burst_left    = 0;
    int msg_items     = 0;
    int ignored_beats = 0;
    int digests_seen  = 0;
    int words_checked = 0;

    sha1_message_digest dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++)
        begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                w[r%16] = rotl(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1md_pkg::K_P0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_P1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1md_pkg::K_P2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_P3;
            end
            t = rotl(a, 5) + f + e + k + w[r%16];
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
        chain_h[3] += d; chain_h[4] += e;
    endtask

    task automatic restart_hash();
        int i;
        for (i = 0; i < sha1md_pkg::NUM_CHAIN; i++)
        begin
            chain_h[i] = sha1md_pkg::CHAIN_IV[i];
        end
        msg_bytes = '0;
    endtask

    // absorb one accepted beat; on an end beat pad, finish and hand back the digest
    task automatic absorb_beat(input logic [7:0] data, input logic present,
                               input logic last, output logic done,
                               output logic [159:0] digest);
        int pos;
        int i;
        logic [63:0] bit_len;
        done   = 1'b0;
        digest = '0;
        if (present)
        begin
            msg_block[msg_bytes[5:0]] = data;
            msg_bytes = msg_bytes + 1'b1;
            if (msg_bytes[5:0] == 6'd0)
                compress_block();
        end
        if (!last)
            return;
        pos = msg_bytes[5:0];
        msg_block[pos] = sha1md_pkg::PAD_MARK_BYTE;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        bit_len = {msg_bytes, 3'b000};
        for (i = 0; i < 8; i++)
        begin
            msg_block[56+i] = bit_len[8*(7-i) +: 8];
        end
        compress_block();
        digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
        done   = 1'b1;
        restart_hash();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] digest beat %0d: %s got %h, want %h", $realtime, words_checked,
                 what, got, want);
        mismatches++;
    endtask

    // drive one beat, hold it until taken, then update the mirrored hash
    task automatic drive_beat(input logic [7:0] data, input logic present, input logic last,
                              input logic known, input logic [159:0] known_digest);
        logic         done;
        logic [159:0] digest;
        digest_beat_t beat;
        int i;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        if (!present && !last)
            ignored_beats++;
        absorb_beat(data, present, last, done, digest);
        if (done)
        begin
            if (known)
                digest = known_digest;
            for (i = 0; i < sha1md_pkg::NUM_CHAIN; i++)
            begin
                beat.word = digest[159-32*i -: 32];
                beat.idx  = i[2:0];
                beat.last = (i[2:0] == sha1md_pkg::WIDX_LAST);
                digest_q  = {digest_q, beat};
            end
            digests_seen++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver: switches between always ready, coin-toss and one-in-four
    int rx_mode = 0;
    int rx_left = 0;
    int rx_tick = 0;

    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    report_mismatch("unexpected beat", m_tdata, 32'h0);
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (m_tdata !== want.word)
                        report_mismatch("digest_word", m_tdata, want.word);
                    if (m_tuser !== want.idx)
                        report_mismatch("word_index", {29'd0, m_tuser}, {29'd0, want.idx});
                    if (m_tlast !== want.last)
                        report_mismatch("last_word", {31'd0, m_tlast}, {31'd0, want.last});
                end
                words_checked++;
            end
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(16, 80);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (rx_tick % 4 == 0);
            endcase
        end
    end

    initial
    begin
        #3000000;
        $display("timeout waiting for digest beats");
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int r;
        int j;
        int len;
        bit sep_end;
        bit drained;
        dir_rows = '{
            '{8'h00, 1'b0, 1'b1, 1'b1, SHA_EMPTY},   // empty message
            '{8'h00, 1'b0, 1'b1, 1'b1, SHA_EMPTY},   // empty again, back to back
            '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h63, 1'b1, 1'b1, 1'b0, 160'h0},      // byte and end on one beat
            '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},      // ignored between messages
            '{8'h61, 1'b1, 1'b1, 1'b0, 160'h0},
            '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},      // ignored inside a message
            '{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h7f, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'h5a, 1'b0, 1'b1, 1'b0, 160'h0},      // end on its own after bytes
            '{8'h01, 1'b1, 1'b0, 1'b0, 160'h0},
            '{8'hfe, 1'b1, 1'b1, 1'b0, 160'h0},
            '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0}
        };
        restart_hash();
        for (j = 0; j < 64; j++)
        begin
            msg_block[j] = 8'h00;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < NUM_ROWS; r++)
        begin
            drive_beat(dir_rows[r].data, dir_rows[r].present, dir_rows[r].last,
                       dir_rows[r].known, dir_rows[r].digest);
        end

        drained = 1'b0;
        while (msg_items < RANDOM_ITEMS)
        begin
            if (!drained && msg_items >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
            // lengths around the padding and block boundaries now and then
            len = ($urandom_range(0, 9) < 3) ? boundary_len[$urandom_range(0, 5)]
                                             : $urandom_range(0, 24);
            sep_end = (len == 0) || ($urandom_range(0, 3) == 0);
            for (j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 11) == 0)
                    drive_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 160'h0);
                drive_beat(8'($urandom_range(0, 255)), 1'b1, !sep_end && (j == len - 1),
                           1'b0, 160'h0);
                msg_items++;
            end
            if (sep_end)
            begin
                drive_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 160'h0);
                msg_items++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d directed rows, %0d random message beats, %0d ignored beats",
                 NUM_ROWS, msg_items, ignored_beats);
        $display("%0d digests predicted, %0d digest words checked", digests_seen,
                 words_checked);
        if (mismatches == 0 && digest_q.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
